[hdl/radial_brush_splat_engine_defines.svh]
// ----------------------------------------------------------------------------
// radial_brush_splat_engine_defines
// assertion macros used by the splat engine datapath (rbse_dpath)
// ----------------------------------------------------------------------------
`ifndef RADIAL_BRUSH_SPLAT_ENGINE_DEFINES_SVH
`define RADIAL_BRUSH_SPLAT_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RBSE_ASSERT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define RBSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define RBSE_ASSERT(name, clk, rst, ante, cons)
`define RBSE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[hdl/rbse_pkg.sv]
// ----------------------------------------------------------------------------
// rbse_pkg
// shared widths, register map, datapath commands and status
// ----------------------------------------------------------------------------
package rbse_pkg;

  localparam int POS_W       = 8;
  localparam int CHAN_W      = 2;
  localparam int COLOR_W     = 16;
  localparam int BRUSH_REG_W = 7;
  localparam int WEIGHT_W    = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [BRUSH_REG_W-1:0] BRUSH_RESET  = 7'd40;
  localparam logic [WEIGHT_W-1:0]    WEIGHT_RESET = 17'd16384;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BRUSH_WIDTH  = 2'd0,
    REG_BRUSH_HEIGHT = 2'd1,
    REG_WEIGHT_X     = 2'd2,
    REG_WEIGHT_Y     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BRUSH_REG_W-1:0] brush_width;
    logic [BRUSH_REG_W-1:0] brush_height;
    logic [WEIGHT_W-1:0]    weight_x;
    logic [WEIGHT_W-1:0]    weight_y;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_REDUCE,
    OP_FETCH,
    OP_RESULT,
    OP_SQUARE,
    OP_WEIGHT,
    OP_SUM,
    OP_DIV,
    OP_MUL,
    OP_WRITE
  } op_t;

  typedef struct packed {
    logic clear_done;
    logic reduced;
    logic is_read;
    logic chan_ok;
    logic empty;
    logic div_done;
    logic last_h;
    logic last_v;
  } stat_t;

endpackage

[hdl/rbse_if.sv]
// ----------------------------------------------------------------------------
// rbse_if
// request and response channels of the splat engine
// ----------------------------------------------------------------------------
interface rbse_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [rbse_pkg::POS_W-1:0]    pos_x;
  logic [rbse_pkg::POS_W-1:0]    pos_y;
  logic [rbse_pkg::CHAN_W-1:0]   channel;
  logic signed [rbse_pkg::COLOR_W-1:0] color;

  modport source (output valid, kind, pos_x, pos_y, channel, color, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, channel, color, output ready);
endinterface

interface rbse_rsp_if #(
  parameter int LEVEL_W = 9
);
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

[hdl/rbse_cfg.sv]
// ----------------------------------------------------------------------------
// rbse_cfg
// brush size and falloff weight registers
// ----------------------------------------------------------------------------
module rbse_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rbse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rbse_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rbse_pkg::cfg_t                    cfg
);
  import rbse_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brush_width  <= BRUSH_RESET;
      cfg.brush_height <= BRUSH_RESET;
      cfg.weight_x     <= WEIGHT_RESET;
      cfg.weight_y     <= WEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BRUSH_WIDTH:  cfg.brush_width  <= cfg_data[BRUSH_REG_W-1:0];
        REG_BRUSH_HEIGHT: cfg.brush_height <= cfg_data[BRUSH_REG_W-1:0];
        REG_WEIGHT_X:     cfg.weight_x     <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_Y:     cfg.weight_y     <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hdl/rbse_ctrl.sv]
// ----------------------------------------------------------------------------
// rbse_ctrl
// sequencer: store clearing, request intake, per-pixel stamp steps
// ----------------------------------------------------------------------------
module rbse_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  rbse_pkg::stat_t stat,
  output rbse_pkg::op_t   op
);
  import rbse_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_FETCH,
    ST_RESULT,
    ST_SQUARE,
    ST_WEIGHT,
    ST_SUM,
    ST_DIV,
    ST_MUL,
    ST_WRITE
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    op         = OP_NOP;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          op         = OP_LOAD;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        op = OP_REDUCE;
        if (stat.reduced) begin
          if (stat.is_read) state_next = ST_FETCH;
          else if (stat.empty || !stat.chan_ok) state_next = ST_IDLE;
          else state_next = ST_SQUARE;
        end
      end
      ST_FETCH: begin
        op         = OP_FETCH;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        // wait for the output register to free up
        if (!rsp_valid || rsp_ready) begin
          op         = OP_RESULT;
          state_next = ST_IDLE;
        end
      end
      ST_SQUARE: begin
        op         = OP_SQUARE;
        state_next = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        op         = OP_WEIGHT;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        op         = OP_SUM;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        op = OP_DIV;
        if (stat.div_done) state_next = ST_MUL;
      end
      ST_MUL: begin
        op         = OP_MUL;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        op = OP_WRITE;
        if (stat.last_h && stat.last_v) state_next = ST_IDLE;
        else state_next = ST_SQUARE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_RESULT) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

[hdl/rbse_dpath.sv]
// ----------------------------------------------------------------------------
// rbse_dpath
// image store, coordinate walk, falloff divider and level update
// ----------------------------------------------------------------------------
`include "radial_brush_splat_engine_defines.svh"

module rbse_dpath #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256,
  parameter int CHANNELS     = 3,
  parameter int MAX_LEVEL    = 256,
  parameter int MAX_BRUSH    = 64,
  parameter int LVW          = 9
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rbse_pkg::op_t                      op,
  input  rbse_pkg::cfg_t                     cfg,
  input  logic                               kind,
  input  logic [rbse_pkg::POS_W-1:0]         pos_x,
  input  logic [rbse_pkg::POS_W-1:0]         pos_y,
  input  logic [rbse_pkg::CHAN_W-1:0]        channel,
  input  logic signed [rbse_pkg::COLOR_W-1:0] color,
  output logic [LVW-1:0]                     level,
  output rbse_pkg::stat_t                    stat
);
  import rbse_pkg::*;

  localparam int DEPTH   = IMAGE_WIDTH * IMAGE_HEIGHT * CHANNELS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int XR_W    = ($clog2(IMAGE_WIDTH + 1) > POS_W) ? $clog2(IMAGE_WIDTH + 1) : POS_W;
  localparam int YR_W    = ($clog2(IMAGE_HEIGHT + 1) > POS_W) ? $clog2(IMAGE_HEIGHT + 1) : POS_W;
  localparam int BW_W    = $clog2(MAX_BRUSH + 1);
  localparam int SQ_W    = 2 * BW_W;
  localparam int PW      = SQ_W + WEIGHT_W;
  localparam int DEN_W   = PW + 2;
  localparam int QW      = LVW;
  localparam int SC_W    = $clog2(QW);
  localparam int NUM_W   = QW + 16;
  localparam int PROD_W  = QW + 1 + COLOR_W;
  localparam int SUM_W   = QW + 18;

  localparam logic [NUM_W-1:0] NUM      = NUM_W'(MAX_LEVEL) << 16;
  localparam logic [QW-1:0]    NUM_LO   = NUM[QW-1:0];
  localparam logic [DEN_W-1:0] REM_INIT = DEN_W'(NUM >> QW);
  localparam logic [LVW-1:0]   MID      = LVW'(MAX_LEVEL / 2);

  // image store
  logic [LVW-1:0]    store [DEPTH];
  logic [LVW-1:0]    rd_data;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [LVW-1:0]    wr_data;
  logic              wr_en;
  logic              rd_en;

  // request and walk registers
  logic                      is_read;
  logic [CHAN_W-1:0]         chan;
  logic signed [COLOR_W-1:0] color_r;
  logic [XR_W-1:0]           x0;
  logic [XR_W-1:0]           col;
  logic [YR_W-1:0]           row;
  logic [BW_W-1:0]           h;
  logic [BW_W-1:0]           v;

  // falloff arithmetic
  logic [SQ_W-1:0]           dh_sq;
  logic [SQ_W-1:0]           dv_sq;
  logic [PW-1:0]             wx_term;
  logic [PW-1:0]             wy_term;
  logic [DEN_W-1:0]          den;
  logic [DEN_W-1:0]          rem;
  logic [QW-1:0]             quo;
  logic [SC_W-1:0]           step;
  logic signed [PROD_W-1:0]  prod;

  logic [BW_W-1:0]           bw;
  logic [BW_W-1:0]           bh;
  logic signed [BW_W:0]      dh;
  logic signed [BW_W:0]      dv;
  logic signed [2*BW_W+1:0]  dh_full;
  logic signed [2*BW_W+1:0]  dv_full;
  logic [XR_W-1:0]           x0_red;
  logic [YR_W-1:0]           row_red;
  logic [XR_W-1:0]           col_inc;
  logic [YR_W-1:0]           row_inc;
  logic                      div_bit;
  logic [DEN_W+1:0]          diff;
  logic                      take;
  logic signed [SUM_W-1:0]   s_sum;
  logic [QW+1:0]             lv_q;
  logic [LVW-1:0]            new_level;
  logic                      chan_ok;

  // footprint clipped to the largest brush
  assign bw = (32'(cfg.brush_width) > MAX_BRUSH) ? BW_W'(MAX_BRUSH) : BW_W'(cfg.brush_width);
  assign bh = (32'(cfg.brush_height) > MAX_BRUSH) ? BW_W'(MAX_BRUSH) : BW_W'(cfg.brush_height);

  assign dh      = $signed({1'b0, h}) - $signed({1'b0, bw >> 1});
  assign dv      = $signed({1'b0, v}) - $signed({1'b0, bh >> 1});
  assign dh_full = dh * dh;
  assign dv_full = dv * dv;

  assign x0_red  = (x0 >= XR_W'(IMAGE_WIDTH)) ? x0 - XR_W'(IMAGE_WIDTH) : x0;
  assign row_red = (row >= YR_W'(IMAGE_HEIGHT)) ? row - YR_W'(IMAGE_HEIGHT) : row;
  assign col_inc = (col == XR_W'(IMAGE_WIDTH - 1)) ? '0 : col + 1'b1;
  assign row_inc = (row == YR_W'(IMAGE_HEIGHT - 1)) ? '0 : row + 1'b1;

  assign chan_ok = 32'(chan) < CHANNELS;

  // restoring divider, one quotient bit per step
  assign div_bit = NUM_LO[SC_W'(QW - 1) - step];
  assign diff    = {1'b0, rem, div_bit} - {2'b00, den};
  assign take    = !diff[DEN_W+1];

  // level update in q15, negative sums clamp to zero, sums above MAX_LEVEL to MAX_LEVEL
  assign s_sum     = $signed({3'b000, rd_data, 15'b0}) + SUM_W'(prod);
  assign lv_q      = s_sum[QW+16:15];
  assign new_level = s_sum[SUM_W-1] ? '0 :
                     (lv_q > (QW+2)'(MAX_LEVEL)) ? LVW'(MAX_LEVEL) : lv_q[QW-1:0];

  assign addr = (ADDR_W'(col) * ADDR_W'(IMAGE_HEIGHT) + ADDR_W'(row)) * ADDR_W'(CHANNELS)
                + ADDR_W'(chan);

  assign wr_en   = (op == OP_CLEAR) || (op == OP_WRITE);
  assign wr_addr = (op == OP_CLEAR) ? clr_addr : addr;
  assign wr_data = (op == OP_CLEAR) ? MID : new_level;
  assign rd_en   = (op == OP_SQUARE) || ((op == OP_FETCH) && chan_ok);

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    if (rd_en) rd_data <= store[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (op == OP_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        is_read <= kind;
        chan    <= channel;
        color_r <= color;
        x0      <= XR_W'(pos_x);
        row     <= YR_W'(pos_y);
        h       <= '0;
        v       <= '0;
      end
      OP_REDUCE: begin
        x0  <= x0_red;
        col <= x0_red;
        row <= row_red;
      end
      OP_SQUARE: begin
        dh_sq <= dh_full[SQ_W-1:0];
        dv_sq <= dv_full[SQ_W-1:0];
      end
      OP_WEIGHT: begin
        wx_term <= PW'(dh_sq) * PW'(cfg.weight_x);
        wy_term <= PW'(dv_sq) * PW'(cfg.weight_y);
      end
      OP_SUM: begin
        den  <= DEN_W'(32'd65536) + DEN_W'(wx_term) + DEN_W'(wy_term);
        rem  <= REM_INIT;
        quo  <= '0;
        step <= '0;
      end
      OP_DIV: begin
        rem  <= take ? diff[DEN_W-1:0] : {rem[DEN_W-2:0], div_bit};
        quo  <= {quo[QW-2:0], take};
        step <= step + 1'b1;
      end
      OP_MUL: begin
        prod <= $signed({1'b0, quo}) * color_r;
      end
      OP_WRITE: begin
        if (stat.last_h) begin
          h   <= '0;
          col <= x0;
          v   <= v + 1'b1;
          row <= row_inc;
        end else begin
          h   <= h + 1'b1;
          col <= col_inc;
        end
      end
      OP_RESULT: begin
        level <= chan_ok ? rd_data : '0;
      end
      default: ;
    endcase
  end

  assign stat.clear_done = (clr_addr == ADDR_W'(DEPTH - 1));
  assign stat.reduced    = (x0 < XR_W'(IMAGE_WIDTH)) && (row < YR_W'(IMAGE_HEIGHT));
  assign stat.is_read    = is_read;
  assign stat.chan_ok    = chan_ok;
  assign stat.empty      = (bw == '0) || (bh == '0);
  assign stat.div_done   = (step == SC_W'(QW - 1));
  assign stat.last_h     = (h == bw - 1'b1);
  assign stat.last_v     = (v == bh - 1'b1);

  `RBSE_ASSERT(a_rem_below_den, clk, rst, op == OP_DIV, rem < den)
  `RBSE_ASSERT(a_quo_in_range, clk, rst, op == OP_MUL, quo <= QW'(MAX_LEVEL))
  `RBSE_ASSERT(a_walk_in_image, clk, rst, op == OP_SQUARE, (col < XR_W'(IMAGE_WIDTH)) && (row < YR_W'(IMAGE_HEIGHT)))
  `RBSE_ASSERT_NEXT(a_div_then_mul, clk, rst, (op == OP_DIV) && stat.div_done, op == OP_MUL)

endmodule

[hdl/radial_brush_splat_engine.sv]
// ----------------------------------------------------------------------------
// radial_brush_splat_engine
// Stamps soft radial brushes into a wrap-around per-channel image store.
// Requests come in on req (valid/ready): kind 0 stamps a footprint with its
// top-left corner at (pos_x, pos_y), kind 1 reads one stored level, which
// leaves on rsp (valid/ready). Brush size and falloff weights are set
// through cfg_write/cfg_index/cfg_data; the user must write them only
// while the engine is idle, which the block itself does not enforce.
// After reset the store is swept to mid gray, one entry per cycle, and
// req.ready stays low during the sweep; configuration writes are taken
// throughout. One request is handled at a time. The corner is wrapped
// by repeated subtraction of the image size. A read then passes a fetch
// and a result step to its response. A stamp pixel passes the square,
// weight, sum, divide, multiply and write steps, with a bit-per-cycle
// falloff divider and the store's read-modify-write. A response that is
// not taken waits in the output register while the next request is
// accepted; a further read then holds until rsp is free.
// ----------------------------------------------------------------------------
module radial_brush_splat_engine #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256,
  parameter int CHANNELS     = 3,
  parameter int MAX_LEVEL    = 256,
  parameter int MAX_BRUSH    = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [rbse_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rbse_pkg::CFG_DATA_W-1:0]  cfg_data,
  rbse_req_if.sink                         req,
  rbse_rsp_if.source                       rsp
);
  import rbse_pkg::*;

  localparam int LVW = $clog2(MAX_LEVEL + 1);

  cfg_t           cfg;
  op_t            op;
  stat_t          stat;
  logic [LVW-1:0] level;

  rbse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .op        (op)
  );

  rbse_dpath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .CHANNELS     (CHANNELS),
    .MAX_LEVEL    (MAX_LEVEL),
    .MAX_BRUSH    (MAX_BRUSH),
    .LVW          (LVW)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .cfg     (cfg),
    .kind    (req.kind),
    .pos_x   (req.pos_x),
    .pos_y   (req.pos_y),
    .channel (req.channel),
    .color   (req.color),
    .level   (level),
    .stat    (stat)
  );

  assign rsp.level = level;

endmodule
